/* hw/rtl/mror_pkg.sv */
// Shared constants and types for the multi-reader overwrite ring.
`timescale 1ns / 1ps

package mror_pkg;

  // Build-time defaults for the top-level parameters.
  localparam int MAX_QUEUE_DEF = 16;
  localparam int MSG_WIDTH_DEF = 64;

  // Fixed field widths of the stream and register ports.
  localparam int MODE_W     = 2;
  localparam int MSG_PORT_W = 64;
  localparam int GEN_W      = 32;
  localparam int CFG_QD_W   = 5;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Operation codes carried in in_tuser.
  localparam logic [MODE_W-1:0] MODE_PUBLISH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;

  // Register map: the word index is paddr[2].
  localparam logic REG_QUEUE_DEPTH = 1'b0;
  localparam logic [CFG_QD_W-1:0] QUEUE_DEPTH_RST = 5'd1;

  // The remainder unit takes one dividend bit per cycle.
  localparam int DIV_STEPS = GEN_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

endpackage

/* hw/rtl/mror_rem.sv */
// Bit-serial restoring remainder unit: 32-bit dividend modulo a small divisor.
`timescale 1ns / 1ps

module mror_rem #(
  parameter int DEPTH_W = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mror_pkg::GEN_W-1:0] dividend,
  input  logic [DEPTH_W-1:0]        divisor,
  output mror_pkg::rem_stat_t       stat,
  output logic [DEPTH_W-1:0]        rem
);

  localparam logic [mror_pkg::DIV_CNT_W-1:0] CNT_LAST =
    mror_pkg::DIV_CNT_W'(mror_pkg::DIV_STEPS - 1);

  logic                       busy_r;
  logic                       done_r;
  logic [mror_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [mror_pkg::GEN_W-1:0] dvd_r;
  logic [DEPTH_W-1:0]         rem_r;
  logic [DEPTH_W-1:0]         rem_nxt;
  logic [DEPTH_W:0]           trial;
  logic [DEPTH_W:0]           dsr_ext;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    trial   = {rem_r, dvd_r[mror_pkg::GEN_W-1]};
    dsr_ext = {1'b0, divisor};
    if (trial >= dsr_ext) begin
      rem_nxt = DEPTH_W'(trial - dsr_ext);
    end else begin
      rem_nxt = trial[DEPTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[mror_pkg::GEN_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule

/* hw/rtl/mror_store.sv */
// Message slot memory: one write port and one registered read port.
`timescale 1ns / 1ps

module mror_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/multi_reader_overwrite_ring.sv */
// Top level of the multi-reader overwrite ring: sequencer, counters and ports.
// A query, an unused mode or a read before any publish goes from an accepted beat straight to
// the output register; a publish first runs the serial remainder, and a read also the lag
// check, step back and slot read. One beat is in flight at a time: in_tready returns once the
// result is loaded, which waits while the previous result is held by a low out_tready.
// rst_n is synchronous and active low: it clears the counters, the data-present flag, the
// sequencer and out_tvalid, and sets queue_depth to 1; the slot memory is not cleared.
`timescale 1ns / 1ps

module multi_reader_overwrite_ring #(
  parameter int MAX_QUEUE = mror_pkg::MAX_QUEUE_DEF,
  parameter int MSG_WIDTH = mror_pkg::MSG_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // message_word [63:0], reader_generation [95:64]
  input  logic [1:0]   in_tuser,   // mode [1:0]
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // read_message [63:0], next_generation [95:64],
                                   // lost_total [127:96], publish_total [159:128]
  output logic [1:0]   out_tuser,  // data_valid [0], updated [1]
  // Register port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [mror_pkg::APB_ADDR_W-1:0]   cfg_paddr,
  input  logic [mror_pkg::APB_DATA_W-1:0]   cfg_pwdata,
  output logic [mror_pkg::APB_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam int GEN_W   = mror_pkg::GEN_W;
  localparam int DEPTH_W = $clog2(MAX_QUEUE + 1);
  localparam int IDX_W   = (MAX_QUEUE > 1) ? $clog2(MAX_QUEUE) : 1;

  // The sequencer walks a read through the lag check, the step back, the remainder and
  // the slot read if data is present; a publish goes to the remainder; others skip all.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LAG  = 6'b000010,
    S_BACK = 6'b000100,
    S_DIV  = 6'b001000,
    S_MEM  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [mror_pkg::CFG_QD_W-1:0] queue_depth_r;
  logic [GEN_W-1:0]              pc_r;
  logic                          has_data_r;
  logic [GEN_W-1:0]              lost_r;

  logic [mror_pkg::MODE_W-1:0] mode_r;
  logic [MSG_WIDTH-1:0]        word_r;
  logic [GEN_W-1:0]            gen_r;
  logic [mror_pkg::MSG_PORT_W-1:0] msg_r;

  logic         out_tvalid_r;
  logic [159:0] out_tdata_r;
  logic [1:0]   out_tuser_r;

  logic             in_acc;
  logic             cfg_wr;
  logic [GEN_W-1:0] depth32;
  logic [DEPTH_W-1:0] depth;
  logic [GEN_W-1:0] reach;
  logic [GEN_W-1:0] gen_back;
  logic             out_load;
  logic             upd;
  logic [mror_pkg::MSG_PORT_W-1:0] rd_ext;

  logic                 rem_start;
  logic [GEN_W-1:0]     rem_dvd;
  mror_pkg::rem_stat_t  rem_stat;
  logic [DEPTH_W-1:0]   rem;
  logic                 mem_wr;
  logic                 mem_rd;
  logic [MSG_WIDTH-1:0] mem_rdata;

  // ---------------------------------------------------------------------------
  // Register port. The depth register is written in the access cycle of a write;
  // the effective depth is clamped into 1..MAX_QUEUE.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[2] == mror_pkg::REG_QUEUE_DEPTH);

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == mror_pkg::REG_QUEUE_DEPTH) begin
      cfg_prdata = mror_pkg::APB_DATA_W'(queue_depth_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_depth_r <= mror_pkg::QUEUE_DEPTH_RST;
    end else if (cfg_wr) begin
      queue_depth_r <= cfg_pwdata[mror_pkg::CFG_QD_W-1:0];
    end
  end

  always_comb begin
    depth32 = GEN_W'(queue_depth_r);
    if (depth32 == '0) begin
      depth32 = GEN_W'(1);
    end else if (depth32 > GEN_W'(MAX_QUEUE)) begin
      depth32 = GEN_W'(MAX_QUEUE);
    end
    depth = depth32[DEPTH_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Datapath helpers. Each sequencer step uses only a short chain of wide adds
  // and compares.
  // ---------------------------------------------------------------------------
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // A reader further than one ring behind is pulled up to the oldest kept slot.
  assign reach = gen_r + depth32;

  // A reader that is fully caught up rereads the newest message.
  assign gen_back = ((pc_r == gen_r) && (gen_r != '0)) ? gen_r - 1'b1 : gen_r;

  assign rem_start = (in_acc && (in_tuser == mror_pkg::MODE_PUBLISH)) || (state_r == S_BACK);
  assign rem_dvd   = (state_r == S_BACK) ? gen_back : pc_r;

  mror_rem #(
    .DEPTH_W (DEPTH_W)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rem_dvd),
    .divisor  (depth),
    .stat     (rem_stat),
    .rem      (rem)
  );

  // The remainder is below the depth, so its low bits address the slot directly.
  assign mem_wr = (state_r == S_DIV) && rem_stat.done && (mode_r == mror_pkg::MODE_PUBLISH);
  assign mem_rd = (state_r == S_DIV) && rem_stat.done && (mode_r == mror_pkg::MODE_READ);

  mror_store #(
    .DEPTH (MAX_QUEUE),
    .WIDTH (MSG_WIDTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (rem[IDX_W-1:0]),
    .wr_data (word_r),
    .rd_en   (mem_rd),
    .rd_addr (rem[IDX_W-1:0]),
    .rd_data (mem_rdata)
  );

  always_comb begin
    rd_ext = '0;
    rd_ext[MSG_WIDTH-1:0] = mem_rdata;
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            mror_pkg::MODE_PUBLISH: state_nxt = S_DIV;
            mror_pkg::MODE_READ:    state_nxt = has_data_r ? S_LAG : S_DONE;
            default:                state_nxt = S_DONE;
          endcase
        end
      end
      S_LAG:  state_nxt = S_BACK;
      S_BACK: state_nxt = S_DIV;
      S_DIV: begin
        if (rem_stat.done) begin
          state_nxt = (mode_r == mror_pkg::MODE_READ) ? S_MEM : S_DONE;
        end
      end
      S_MEM:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pc_r       <= '0;
      has_data_r <= 1'b0;
      lost_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (mem_wr) begin
        pc_r       <= pc_r + 1'b1;
        has_data_r <= 1'b1;
      end
      if ((state_r == S_LAG) && (pc_r > reach)) begin
        lost_r <= lost_r + (pc_r - reach);
      end
    end
  end

  // Per-beat working registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_tuser;
      word_r <= in_tdata[MSG_WIDTH-1:0];
      gen_r  <= in_tdata[95:64];
      msg_r  <= '0;
    end else begin
      case (state_r)
        S_LAG: begin
          if (pc_r > reach) begin
            gen_r <= pc_r - depth32;
          end
        end
        S_BACK: gen_r <= gen_back;
        S_MEM: begin
          msg_r <= rd_ext;
          if (gen_r < pc_r) begin
            gen_r <= gen_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: loaded from the finished beat when empty or being drained.
  // ---------------------------------------------------------------------------
  assign out_load = (state_r == S_DONE) && (!out_tvalid_r || out_tready);
  assign upd = (mode_r == mror_pkg::MODE_QUERY) && has_data_r && (gen_r != pc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {pc_r, lost_r, gen_r, msg_r};
      out_tuser_r <= {upd, has_data_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_pc_bump: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr |=> (pc_r == $past(pc_r) + 1'b1))
    else $error("publish count did not advance after a slot write");

  a_lost_only_in_lag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LAG) |=> $stable(lost_r))
    else $error("lost count changed outside the lag check");

  a_no_data_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    !has_data_r |-> (pc_r == '0))
    else $error("publish count moved without data present");

  a_rem_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rem_start |-> !rem_stat.busy)
    else $error("remainder unit restarted while busy");

  a_rem_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_stat.done |-> (state_r == S_DIV))
    else $error("remainder finished outside the divide step");

endmodule

/* tb/tb_multi_reader_overwrite_ring.sv */
// Self-checking testbench for the multi-reader overwrite ring with a built-in predictor.
`timescale 1ns / 1ps

module tb_multi_reader_overwrite_ring;
  import mror_pkg::*;

  localparam int RING_SLOTS = MAX_QUEUE_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int TOTAL_BEATS = 950;
  localparam int DIRECTED_BEATS = 25;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 60;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [63:0] msg;
    logic [31:0] next_gen;
    logic        valid;
    logic        upd;
    logic [31:0] lost;
    logic [31:0] pubs;
  } ring_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [95:0]           in_tdata = '0;    // message_word [63:0], reader_generation [95:64]
  logic [1:0]            in_tuser = '0;    // mode [1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [159:0]          out_tdata;        // read_message, next_generation, lost, publish
  logic [1:0]            out_tuser;        // data_valid [0], updated [1]
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  multi_reader_overwrite_ring i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the ring. The slot store is never cleared by reset, so the
  // written flags keep track of which slots a read may legally reach.
  logic [63:0] ring_store [RING_SLOTS];
  bit          slot_written [RING_SLOTS];
  logic [31:0] ring_pubs = '0;
  logic        ring_has = 1'b0;
  logic [31:0] ring_lost = '0;
  logic [CFG_QD_W-1:0] ring_depth_reg = QUEUE_DEPTH_RST;

  ring_result_t pending_results [$];
  int mismatches = 0;
  int results_checked = 0;
  int publish_beats = 0, read_beats = 0, query_beats = 0, unused_beats = 0;
  int depth_writes = 0;
  bit quiet_phase = 1'b0;
  int idle_cycles = 0;

  // Effective depth: zero behaves as one, anything above the build size as the build size.
  function automatic logic [31:0] ring_depth();
    if (ring_depth_reg == '0) return 32'd1;
    if ({27'd0, ring_depth_reg} > 32'(RING_SLOTS)) return 32'(RING_SLOTS);
    return {27'd0, ring_depth_reg};
  endfunction

  // Works out where a reader lands: messages it has missed, the slot it reads and
  // the generation it carries away. Leaves the shadow state untouched.
  function automatic void follow_reader(input logic [31:0] gen, output logic [31:0] gen_out,
                                        output logic [31:0] skipped, output int slot);
    logic [31:0] depth, reach, g;
    depth = ring_depth();
    g = gen;
    skipped = '0;
    reach = g + depth;
    if (ring_pubs > reach) begin
      skipped = ring_pubs - reach;
      g = ring_pubs - depth;
    end
    if (ring_pubs == g && g != '0) g = g - 32'd1;
    slot = int'(g % depth);
    if (g < ring_pubs) g = g + 32'd1;
    gen_out = g;
  endfunction

  function automatic ring_result_t ring_apply(input logic [MODE_W-1:0] mode,
                                              input logic [63:0] word, input logic [31:0] gen);
    ring_result_t r;
    logic [31:0] g, skipped;
    int slot;
    r = '0;
    r.next_gen = gen;
    case (mode)
      MODE_PUBLISH: begin
        slot = int'(ring_pubs % ring_depth());
        ring_store[slot] = word;
        slot_written[slot] = 1'b1;
        ring_pubs = ring_pubs + 32'd1;
        ring_has = 1'b1;
      end
      MODE_READ: begin
        if (ring_has) begin
          follow_reader(gen, g, skipped, slot);
          ring_lost = ring_lost + skipped;
          r.msg = ring_store[slot];
          r.next_gen = g;
        end
      end
      MODE_QUERY: begin
        r.upd = ring_has && (gen != ring_pubs);
      end
      default: begin
      end
    endcase
    r.valid = ring_has;
    r.lost = ring_lost;
    r.pubs = ring_pubs;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < MAX_PRINTED)
      $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Mostly short pauses, now and then a long one.
  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  // Sends one beat and records what the ring should answer. A read that would land
  // on a slot never written is outside the contract, so it becomes a publish instead.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [63:0] word,
                           input logic [31:0] gen);
    logic [31:0] g, skipped;
    int slot, gap;
    if (mode == MODE_READ && ring_has) begin
      follow_reader(gen, g, skipped, slot);
      if (!slot_written[slot]) mode = MODE_PUBLISH;
    end
    gap = (quiet_phase || $urandom_range(0, 99) < 60) ? 0 : idle_length();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {gen, word};
    in_tuser  <= mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(ring_apply(mode, word, gen));
    case (mode)
      MODE_PUBLISH: publish_beats++;
      MODE_READ:    read_beats++;
      MODE_QUERY:   query_beats++;
      default:      unused_beats++;
    endcase
  endtask

  // Drops the input valid and waits until every result has come back.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {REG_QUEUE_DEPTH, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Writes queue_depth while the ring is idle and reads it back.
  task automatic set_depth(input logic [CFG_QD_W-1:0] value);
    logic [31:0] rd;
    wait_idle();
    cfg_access(1'b1, {27'd0, value}, rd);
    ring_depth_reg = value;
    depth_writes++;
    cfg_access(1'b0, '0, rd);
    if (rd !== {27'd0, ring_depth_reg})
      flag_mismatch("queue_depth readback", 64'(rd), 64'(ring_depth_reg));
  endtask

  // Reader generations: mostly close behind the writer, plus readers far behind,
  // readers ahead, wholly random values and the two extremes.
  function automatic logic [31:0] pick_generation();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return ring_pubs - $urandom_range(0, ring_depth() + 2);
    if (r < 65) return ring_pubs - $urandom_range(ring_depth() + 3, 200);
    if (r < 75) return ring_pubs + $urandom_range(1, 5);
    if (r < 95) return $urandom;
    return (r < 97) ? 32'd0 : 32'hFFFF_FFFF;
  endfunction

  function automatic logic [63:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return {$urandom, $urandom};
  endfunction

  // Result checker: each beat on the result side is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    ring_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending", out_tdata[63:0], '0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_tdata[63:0] !== want.msg)
          flag_mismatch("read_message", out_tdata[63:0], want.msg);
        if (out_tdata[95:64] !== want.next_gen)
          flag_mismatch("next_generation", 64'(out_tdata[95:64]), 64'(want.next_gen));
        if (out_tuser[0] !== want.valid)
          flag_mismatch("data_valid", 64'(out_tuser[0]), 64'(want.valid));
        if (out_tuser[1] !== want.upd)
          flag_mismatch("updated", 64'(out_tuser[1]), 64'(want.upd));
        if (out_tdata[127:96] !== want.lost)
          flag_mismatch("lost_total", 64'(out_tdata[127:96]), 64'(want.lost));
        if (out_tdata[159:128] !== want.pubs)
          flag_mismatch("publish_total", 64'(out_tdata[159:128]), 64'(want.pubs));
      end
    end
  end

  // Receiver back-pressure: random stalls of varied length, none in quiet phases.
  always @(posedge clk) begin : drive_ready
    int stall_left;
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!quiet_phase && $urandom_range(0, 99) < 20) begin
      out_tready <= 1'b0;
      stall_left = idle_length() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: a run that accepts nothing on any port for too long has hung.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Before any publish a read, a query and an unused mode change nothing.
  task automatic test_empty_ring();
    send_item(MODE_READ, '1, 32'd0);
    send_item(MODE_READ, '0, 32'hFFFF_FFFF);
    send_item(MODE_QUERY, '0, 32'd0);
    send_item(MODE_UNUSED, '1, 32'd5);
  endtask

  // Single slot at reset depth: lagging, caught-up, one-behind and ahead readers.
  task automatic test_single_slot();
    set_depth(5'd1);
    send_item(MODE_PUBLISH, '0, 32'd0);
    send_item(MODE_PUBLISH, '1, 32'hFFFF_FFFF);
    send_item(MODE_READ, '0, 32'd0);
    send_item(MODE_READ, '0, 32'd2);
    send_item(MODE_READ, '0, 32'd1);
    send_item(MODE_READ, '0, 32'd5);
    send_item(MODE_QUERY, '0, 32'd2);
    send_item(MODE_QUERY, '0, 32'd7);
    send_item(MODE_UNUSED, '0, 32'd9);
  endtask

  // Generations near the top of the 32-bit range, where gen + depth wraps round.
  task automatic test_generation_wrap();
    set_depth(5'd4);
    send_item(MODE_PUBLISH, 64'h0123_4567_89AB_CDEF, '0);
    send_item(MODE_PUBLISH, 64'hFEDC_BA98_7654_3210, '0);
    send_item(MODE_PUBLISH, 64'h8000_0000_0000_0001, '0);
    send_item(MODE_PUBLISH, 64'h7FFF_FFFF_FFFF_FFFE, '0);
    send_item(MODE_READ, '0, 32'hFFFF_FFFE);
    send_item(MODE_READ, '0, 32'hFFFF_FFFF);
    send_item(MODE_READ, '0, 32'h8000_0000);
    send_item(MODE_QUERY, '0, 32'hFFFF_FFFF);
  endtask

  // Depth of zero behaves as one; depths above the build size behave as the build size.
  task automatic test_depth_out_of_range();
    set_depth(5'd0);
    send_item(MODE_PUBLISH, 64'h5555_5555_5555_5555, '0);
    send_item(MODE_READ, '0, 32'd0);
    set_depth(5'd31);
    send_item(MODE_PUBLISH, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    send_item(MODE_READ, '0, ring_pubs);
  endtask

  // Random traffic in phases, each with its own depth; some phases run without idling.
  task automatic test_random_traffic();
    logic [CFG_QD_W-1:0] depths [9];
    int per_phase, r;
    logic [MODE_W-1:0] mode;
    depths = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd7, 5'd17, 5'd1, 5'd16, 5'd0};
    depths[8] = CFG_QD_W'($urandom_range(0, 31));
    per_phase = (TOTAL_BEATS - DIRECTED_BEATS) / 9;
    for (int p = 0; p < 9; p++) begin
      set_depth(depths[p]);
      quiet_phase = (p % 3 == 1);
      for (int n = 0; n < per_phase; n++) begin
        r = $urandom_range(0, 99);
        if (r < 35)      mode = MODE_PUBLISH;
        else if (r < 75) mode = MODE_READ;
        else if (r < 92) mode = MODE_QUERY;
        else             mode = MODE_UNUSED;
        send_item(mode, pick_word(), pick_generation());
      end
    end
    quiet_phase = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_ring();
    test_single_slot();
    test_generation_wrap();
    test_depth_out_of_range();
    test_random_traffic();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (pending_results.size() != 0) begin
      flag_mismatch("result never delivered", '0, pending_results[0].msg);
      void'(pending_results.pop_front());
    end

    $display("Run covered %0d publishes, %0d reads, %0d queries and %0d unused-mode beats.",
             publish_beats, read_beats, query_beats, unused_beats);
    $display("%0d results checked over %0d depth settings; %0d messages counted as lost.",
             results_checked, depth_writes, ring_lost);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
